/* src/caseless_substring_search_core_macros.svh */
// Assertion macros for the caseless substring search RTL.
`ifndef CASELESS_SUBSTRING_SEARCH_CORE_MACROS_SVH
`define CASELESS_SUBSTRING_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CSS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CSS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/css_pkg.sv */
// Types, constants and helper functions for the caseless substring search core.
package css_pkg;

   localparam int unsigned MAX_NEEDLE_DEFAULT  = 16;
   localparam int unsigned OFFSET_BITS_DEFAULT = 22;

   localparam int unsigned LEN_BITS       = 5;
   localparam int unsigned NEEDLE_BITS    = 128;
   localparam int unsigned CSR_INDEX_BITS = 8;
   localparam int unsigned CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] REG_NEEDLE_LOW  = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEEDLE_HIGH = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEEDLE_LEN  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WHOLE_WORD  = 8'd3;

   typedef struct packed {
      logic [NEEDLE_BITS-1:0] needle;
      logic [LEN_BITS-1:0]    len;
      logic                   whole_word;
   } cfg_type;

   typedef struct packed {
      logic hit;        // window matches the needle at the configured length
      logic prev_word;  // byte before the window is alphanumeric
   } match_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

/* src/css_req_if.sv */
// Input byte channel: valid/ready with one buffer byte and its end marker.
interface css_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/css_rsp_if.sv */
// Result channel: valid/ready with the found flag and match offset.
interface css_rsp_if #(
   parameter int unsigned OFFSET_BITS = css_pkg::OFFSET_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [OFFSET_BITS-1:0] match_offset;

   modport source (output valid, output found, output match_offset, input ready);
   modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* src/css_csr_if.sv */
// Configuration write channel: valid/ready with register index and data.
interface css_csr_if;
   logic                               valid;
   logic                               ready;
   logic [css_pkg::CSR_INDEX_BITS-1:0] index;
   logic [css_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/css_csr_regs.sv */
// Configuration registers: needle bytes, needle length and whole-word mode.
module css_csr_regs (
   input  logic             clock,
   input  logic             reset,
   css_csr_if.sink          csr,
   output css_pkg::cfg_type cfg
);
   import css_pkg::*;

   logic [CSR_DATA_BITS-1:0] needle_low_ff;
   logic [CSR_DATA_BITS-1:0] needle_high_ff;
   logic [LEN_BITS-1:0]      len_ff;
   logic                     whole_word_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         len_ff         <= '0;
         whole_word_ff  <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_NEEDLE_LOW:  needle_low_ff  <= csr.data;
            REG_NEEDLE_HIGH: needle_high_ff <= csr.data;
            REG_NEEDLE_LEN:  len_ff         <= csr.data[LEN_BITS-1:0];
            REG_WHOLE_WORD:  whole_word_ff  <= csr.data[0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   assign cfg.needle     = {needle_high_ff, needle_low_ff};
   assign cfg.len        = len_ff;
   assign cfg.whole_word = whole_word_ff;
endmodule

/* src/css_window_match.sv */
// Parallel caseless compare of the byte window against the needle.
module css_window_match #(
   parameter int unsigned MAX_NEEDLE = css_pkg::MAX_NEEDLE_DEFAULT
) (
   input  logic [MAX_NEEDLE:0][7:0]              window,  // entry 0 is the newest byte
   input  logic [css_pkg::NEEDLE_BITS-1:0]       needle,
   input  logic [css_pkg::LEN_BITS-1:0]          len,
   output css_pkg::match_type                    result
);
   import css_pkg::*;

   localparam int unsigned WIN_IDX_BITS = $clog2(MAX_NEEDLE + 1);

   always_comb begin
      logic                all_eq;
      logic [LEN_BITS-1:0] idx;
      all_eq = 1'b1;
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         idx = '0;
         if (LEN_BITS'(j) < len) begin
            // needle byte j lines up with window entry len-1-j
            idx = len - LEN_BITS'(j) - LEN_BITS'(1);
            if (fold_case(window[idx[WIN_IDX_BITS-1:0]]) != fold_case(needle[j*8 +: 8])) begin
               all_eq = 1'b0;
            end
         end
      end
      result.hit       = all_eq;
      result.prev_word = is_word_char(window[len[WIN_IDX_BITS-1:0]]);
   end
endmodule

/* src/caseless_substring_search_core.sv */
// Top level of the caseless substring search core with whole-word mode.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    data_byte[7:0], last_byte
//   rsp      out  valid/ready    found, match_offset[OFFSET_BITS-1:0]
//   csr      in   valid/ready    index[7:0], data[63:0]
//
// One byte per cycle sustained; the window compare and state update work on the byte
// in the input register, so the result register loads when the last byte moves on from
// the input register, and the result is offered from the result register. Synchronous
// reset clears the control state and configuration. Only a last byte waits on a held
// result; other bytes keep flowing.
`include "caseless_substring_search_core_macros.svh"
module caseless_substring_search_core #(
   parameter int unsigned MAX_NEEDLE  = css_pkg::MAX_NEEDLE_DEFAULT,
   parameter int unsigned OFFSET_BITS = css_pkg::OFFSET_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   css_req_if.sink   req,
   css_rsp_if.source rsp,
   css_csr_if.sink   csr
);
   import css_pkg::*;

   localparam int unsigned COUNT_BITS = OFFSET_BITS + 1;
   localparam int unsigned SUM_BITS   = OFFSET_BITS + 2;

   cfg_type   cfg;
   match_type match;

   logic                       s1_valid_ff;
   logic [7:0]                 s1_byte_ff;
   logic                       s1_last_ff;
   logic [MAX_NEEDLE-1:0][7:0] hist_ff;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic                       hit_ff, hit_in;
   logic [OFFSET_BITS-1:0]     hit_off_ff, hit_off_in;
   logic                       pend_ff, pend_in;
   logic [OFFSET_BITS-1:0]     pend_off_ff, pend_off_in;
   logic                       out_valid_ff;
   logic                       out_found_ff;
   logic [OFFSET_BITS-1:0]     out_offset_ff;

   logic                       advance;
   logic [MAX_NEEDLE:0][7:0]   window;
   logic [SUM_BITS-1:0]        sum, start_full;
   logic [OFFSET_BITS-1:0]     start;
   logic                       len_ok, reach, fits, cand;

   css_csr_regs u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   always_comb begin
      window[0] = s1_byte_ff;
      for (int k = 1; k <= MAX_NEEDLE; k++) begin
         window[k] = hist_ff[k-1];
      end
   end

   css_window_match #(.MAX_NEEDLE(MAX_NEEDLE)) u_match (
      .window (window),
      .needle (cfg.needle),
      .len    (cfg.len),
      .result (match)
   );

   // A last byte needs the result register free; other bytes always move on.
   assign advance   = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;

   assign sum        = SUM_BITS'(count_ff) + SUM_BITS'(1);
   assign start_full = sum - SUM_BITS'(cfg.len);
   assign start      = start_full[OFFSET_BITS-1:0];
   assign len_ok     = (cfg.len != '0) && (cfg.len <= LEN_BITS'(MAX_NEEDLE));
   assign reach      = sum >= SUM_BITS'(cfg.len);
   assign fits       = start_full[SUM_BITS-1:OFFSET_BITS] == '0;

   always_comb begin
      // settle a waiting whole-word match with this byte
      hit_in      = hit_ff || (pend_ff && !is_word_char(s1_byte_ff));
      hit_off_in  = hit_ff ? hit_off_ff : pend_off_ff;
      pend_in     = 1'b0;
      pend_off_in = pend_off_ff;
      cand        = !hit_in && len_ok && reach && fits && match.hit;
      if (cand) begin
         priority if (!cfg.whole_word) begin
            hit_in     = 1'b1;
            hit_off_in = start;
         end else if (start != '0 && match.prev_word) begin
            // word character before the match: reject
         end else if (s1_last_ff) begin
            hit_in     = 1'b1;
            hit_off_in = start;
         end else begin
            pend_in     = 1'b1;
            pend_off_in = start;
         end
      end
      count_in = (count_ff == '1) ? count_ff : count_ff + COUNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         hit_off_ff   <= '0;
         pend_ff      <= 1'b0;
         pend_off_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (advance && s1_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (s1_last_ff) begin
               // end of buffer: deliver and clear the stream state
               count_ff     <= '0;
               hit_ff       <= 1'b0;
               hit_off_ff   <= '0;
               pend_ff      <= 1'b0;
               pend_off_ff  <= '0;
            end else begin
               count_ff    <= count_in;
               hit_ff      <= hit_in;
               hit_off_ff  <= hit_off_in;
               pend_ff     <= pend_in;
               pend_off_ff <= pend_off_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_byte_ff <= req.data_byte;
         s1_last_ff <= req.last_byte;
      end
      if (advance) begin
         hist_ff[0] <= s1_byte_ff;
         for (int k = 1; k < MAX_NEEDLE; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
         if (s1_last_ff) begin
            out_found_ff  <= hit_in;
            out_offset_ff <= hit_in ? hit_off_in : '0;
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.found        = out_found_ff;
   assign rsp.match_offset = out_offset_ff;

   `CSS_ASSERT_IMP(a_no_offset_without_hit, rsp.valid && !rsp.found, rsp.match_offset == '0, "offset set without a hit")
   `CSS_ASSERT_IMP(a_pending_excludes_hit, pend_ff, !hit_ff, "pending match while a hit is held")
   `CSS_ASSERT_NXT(a_clear_after_last, advance && s1_last_ff, count_ff == '0 && !hit_ff && !pend_ff, "stream state not cleared after last byte")
endmodule

/* test/caseless_substring_search_core_test.sv */
// Self-checking testbench for the caseless substring search core with whole-word mode.

localparam int unsigned OFFSET_W = css_pkg::OFFSET_BITS_DEFAULT;
localparam int unsigned NEEDLE_MAX = css_pkg::MAX_NEEDLE_DEFAULT;
localparam longint unsigned OFFSET_LIMIT = (64'd1 << OFFSET_W) - 64'd1;
localparam longint unsigned COUNT_LIMIT = (64'd1 << (OFFSET_W + 1)) - 64'd1;

typedef logic [OFFSET_W-1:0] offset_type;

typedef struct packed {
   logic       found;
   offset_type offset;
} search_result_type;

function automatic logic [7:0] fold_lower(input logic [7:0] c);
   logic [7:0] folded;
   folded = c;
   if (c >= 8'h41 && c <= 8'h5a) begin
      folded = c | 8'h20;
   end
   return folded;
endfunction

function automatic logic is_alnum(input logic [7:0] c);
   logic [7:0] low;
   low = c | 8'h20;
   return (c >= 8'h30 && c <= 8'h39) || (low >= 8'h61 && low <= 8'h7a);
endfunction

// Tracks the search state of the current buffer and holds the results still owed.
class match_tracker;
   logic [127:0]      needle;
   logic [4:0]        needle_len;
   logic              whole_word;
   logic [7:0]        window [NEEDLE_MAX+1];
   longint unsigned   seen;
   logic              hit;
   offset_type        hit_at;
   logic              waiting;
   offset_type        waiting_at;
   search_result_type awaited [$];
   int unsigned       mismatches;

   function new();
      needle = '0;
      needle_len = '0;
      whole_word = 1'b0;
      mismatches = 0;
      clear_buffer();
   endfunction

   function void clear_buffer();
      foreach (window[k]) window[k] = 8'h00;
      seen = 0;
      hit = 1'b0;
      hit_at = '0;
      waiting = 1'b0;
      waiting_at = '0;
   endfunction

   function void write_register(logic [7:0] index, logic [63:0] value);
      case (index)
         css_pkg::REG_NEEDLE_LOW: needle[63:0] = value;
         css_pkg::REG_NEEDLE_HIGH: needle[127:64] = value;
         css_pkg::REG_NEEDLE_LEN: needle_len = value[4:0];
         css_pkg::REG_WHOLE_WORD: whole_word = value[0];
         default: ;
      endcase
   endfunction

   function void take_byte(logic [7:0] b, logic last);
      longint unsigned count_before;
      longint unsigned start;
      int unsigned len;
      logic same;
      search_result_type res;
      count_before = seen;
      len = needle_len;
      for (int k = NEEDLE_MAX; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      // a held whole-word match is settled by the byte after it
      if (waiting && !hit && !is_alnum(b)) begin
         hit = 1'b1;
         hit_at = waiting_at;
      end
      waiting = 1'b0;
      if (!hit && len >= 1 && len <= NEEDLE_MAX && count_before + 1 >= len) begin
         start = count_before + 1 - len;
         same = 1'b1;
         for (int j = 0; j < len; j++) begin
            if (fold_lower(window[len-1-j]) != fold_lower(needle[8*j +: 8])) same = 1'b0;
         end
         if (same && start <= OFFSET_LIMIT) begin
            if (!whole_word) begin
               hit = 1'b1;
               hit_at = offset_type'(start);
            end else if (!(start > 0 && is_alnum(window[len]))) begin
               if (last) begin
                  hit = 1'b1;
                  hit_at = offset_type'(start);
               end else begin
                  waiting = 1'b1;
                  waiting_at = offset_type'(start);
               end
            end
         end
      end
      if (count_before < COUNT_LIMIT) seen = count_before + 1;
      if (last) begin
         res.found = hit;
         res.offset = hit ? hit_at : '0;
         awaited = {awaited, res};
         clear_buffer();
      end
   endfunction

   function void check_result(logic found, offset_type offset);
      search_result_type want;
      if (awaited.size() == 0) begin
         mismatches++;
         $display("%0t: result with none expected: found %0b offset %0d", $time, found, offset);
         return;
      end
      want = awaited.pop_front();
      if (found !== want.found) begin
         mismatches++;
         $display("%0t: found expected %0b actual %0b", $time, want.found, found);
      end
      if (offset !== want.offset) begin
         mismatches++;
         $display("%0t: match_offset expected %0d actual %0d", $time, want.offset, offset);
      end
   endfunction
endclass

module caseless_substring_search_core_test;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [7:0] REG_UNUSED = 8'hff;

   logic clock;
   logic reset;
   int unsigned cycles = 0;
   bit calm = 1'b0;
   int unsigned gap_odds = 0;
   int unsigned stall_odds = 0;
   int unsigned random_bytes = 0;
   match_tracker tracker = new();

   css_req_if req_bus ();
   css_rsp_if #(.OFFSET_BITS(OFFSET_W)) rsp_bus ();
   css_csr_if csr_bus ();

   caseless_substring_search_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr(csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_result(rsp_bus.found, rsp_bus.match_offset);
      end
   end

   // Result side: hold ready low in random bursts.
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
            hold = $urandom_range(14, 0);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] random_word();
      logic [7:0] c;
      case ($urandom_range(2, 0))
         0: c = 8'h30 + 8'($urandom_range(9, 0));
         1: c = 8'h41 + 8'($urandom_range(25, 0));
         default: c = 8'h61 + 8'($urandom_range(25, 0));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] random_sep();
      logic [7:0] c;
      do c = 8'($urandom_range(255, 0)); while (is_alnum(c));
      return c;
   endfunction

   function automatic logic [7:0] random_char();
      int unsigned r;
      r = $urandom_range(9, 0);
      if (r < 6) return random_word();
      if (r < 8) return random_sep();
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic logic [127:0] text_needle(string s);
      logic [127:0] n;
      n = '0;
      for (int i = 0; i < s.len() && i < 16; i++) n[8*i +: 8] = s[i];
      return n;
   endfunction

   // Leaves valid high; the caller or the next transaction decides what follows.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      if (!calm && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
         gap = $urandom_range(15, 1);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.take_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic write_register(input logic [7:0] index, input logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      tracker.write_register(index, value);
      @(negedge clock);
   endtask

   // Unused upper bits of the length and mode writes carry junk half the time.
   task automatic set_search(input logic [127:0] needle, input logic [4:0] len, input logic ww);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_register(css_pkg::REG_NEEDLE_LOW, needle[63:0]);
      write_register(css_pkg::REG_NEEDLE_HIGH, needle[127:64]);
      write_register(css_pkg::REG_NEEDLE_LEN,
                     $urandom_range(1, 0) ? {junk[63:5], len} : {59'd0, len});
      write_register(css_pkg::REG_WHOLE_WORD,
                     $urandom_range(1, 0) ? {junk[63:1], ww} : {63'd0, ww});
      csr_bus.valid <= 1'b0;
   endtask

   // Hold the sender until every owed result is out, then let the pipeline empty.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.awaited.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic send_random_buffer();
      logic [7:0] stream_q [$];
      logic [7:0] c;
      int unsigned len;
      int unsigned lead_n;
      int unsigned tail_n;
      int unsigned copies;
      len = tracker.needle_len;
      if (len >= 1 && len <= NEEDLE_MAX && $urandom_range(3, 0) != 0) begin
         lead_n = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(6, 0);
         repeat (lead_n) stream_q = {stream_q, random_char()};
         copies = ($urandom_range(3, 0) == 0) ? 2 : 1;
         repeat (copies) begin
            if (stream_q.size() != 0) begin
               stream_q[stream_q.size()-1] = $urandom_range(1, 0) ? random_sep() : random_word();
            end
            for (int j = 0; j < len; j++) begin
               c = tracker.needle[8*j +: 8];
               if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7a && $urandom_range(1, 0)) begin
                  c = c ^ 8'h20;
               end
               stream_q = {stream_q, c};
            end
            if ($urandom_range(5, 0) == 0) begin
               stream_q[stream_q.size() - 1 - $urandom_range(len - 1, 0)] = random_char();
            end
            if ($urandom_range(3, 0) != 0) begin
               c = $urandom_range(1, 0) ? random_sep() : random_word();
               stream_q = {stream_q, c};
            end
         end
         tail_n = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 0);
         repeat (tail_n) stream_q = {stream_q, random_char()};
      end else begin
         repeat ($urandom_range(20, 1)) stream_q = {stream_q, random_char()};
      end
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      random_bytes += stream_q.size();
   endtask

   initial begin
      int unsigned r;
      logic [4:0] len;
      logic [127:0] needle;
      logic ww;
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= 8'h00;
      csr_bus.data <= 64'd0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty needle after reset; a write to an unknown index is dropped
      write_register(REG_UNUSED, {$urandom(), $urandom()});
      csr_bus.valid <= 1'b0;
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      settle();
      // case folding covers letters only
      set_search(text_needle("a["), 5'd2, 1'b0);
      send_text("xA[");
      send_text("A{");
      settle();
      // whole word: end of buffer, alnum after, clean hit
      set_search(text_needle("ab"), 5'd2, 1'b1);
      send_text("aB");
      send_text("-ab9");
      send_text("x-ab ");
      settle();
      // needle longer than the buffer
      set_search(text_needle("abc"), 5'd3, 1'b0);
      send_text("ab");
      settle();
      // lengths above the needle size never match
      set_search(text_needle("a"), 5'd17, 1'b0);
      send_text("a");
      settle();
      set_search({128{1'b1}}, 5'd31, 1'b1);
      send_byte(8'hff, 1'b1);
      settle();

      while (random_bytes < 600) begin
         if (random_bytes >= 480) calm = 1'b1;
         r = $urandom_range(19, 0);
         if (r < 10) len = 5'($urandom_range(4, 1));
         else if (r < 15) len = 5'($urandom_range(8, 5));
         else if (r < 18) len = 5'($urandom_range(16, 9));
         else if (r == 18) len = 5'd16;
         else len = $urandom_range(1, 0) ? 5'd0 : 5'($urandom_range(31, 17));
         case ($urandom_range(7, 0))
            0: needle = {128{1'b1}};
            1: needle = '0;
            default: for (int j = 0; j < 16; j++) needle[8*j +: 8] = random_char();
         endcase
         ww = (len < 6) ? ($urandom_range(3, 0) != 0) : ($urandom_range(3, 0) == 0);
         gap_odds = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 2);
         stall_odds = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 2);
         set_search(needle, len, ww);
         repeat ($urandom_range(8, 3)) begin
            send_random_buffer();
            if ($urandom_range(9, 0) == 0) settle();
         end
         settle();
      end

      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/css_pkg.sv
src/css_req_if.sv
src/css_rsp_if.sv
src/css_csr_if.sv
src/css_csr_regs.sv
src/css_window_match.sv
src/caseless_substring_search_core.sv
test/caseless_substring_search_core_test.sv
